// ===== rtl/core/ps2_mouse_packet_tracker_top_macros.svh =====
// Assertion macros for the PS/2 mouse packet tracker checker.
// The macros expect signals named clk and arst_n in the scope where they are used.
`ifndef PS2_MOUSE_PACKET_TRACKER_TOP_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMPT_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PMPT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pmpt_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; each other file but the macros header imports it.
package pmpt_pkg;

	localparam int COORD_BITS_DEF  = 13;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration port.
	localparam int REG_W     = 14;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;
	localparam logic [REG_W-1:0] SCREEN_WIDTH_RESET  = 14'd1024;
	localparam logic [REG_W-1:0] SCREEN_HEIGHT_RESET = 14'd768;

	// A delta spans -511..510 once the overflow extension is added.
	localparam int DELTA_W = 10;
	typedef logic signed [DELTA_W-1:0] delta_t;

	// One framed packet, already classified into deltas and buttons.
	typedef struct packed {
		delta_t     dx;
		delta_t     dy;
		logic       right;
		logic       middle;
		logic       left;
	} pkt_t;

endpackage

// ===== rtl/core/pmpt_if.sv =====
// Channel interfaces of the PS/2 mouse packet tracker: received bytes and cursor reports.
// Depends on pmpt_pkg for the default coordinate width.
interface pmpt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface pmpt_cursor_if import pmpt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] cursor_x;
	logic [COORD_BITS-1:0] cursor_y;
	logic                  left_button;
	logic                  middle_button;
	logic                  right_button;

	modport source (output valid, output cursor_x, output cursor_y, output left_button,
		output middle_button, output right_button, input ready);
	modport sink (input valid, input cursor_x, input cursor_y, input left_button,
		input middle_button, input right_button, output ready);
endinterface

// ===== rtl/core/pmpt_front.sv =====
// Front end: drops the first byte after reset, frames flags/X/Y packets and forms deltas.
// Depends on pmpt_pkg and the byte channel interface.
module pmpt_front import pmpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pmpt_byte_if.sink   bytes,
	input  logic        queue_full,
	output logic        push,
	output pkt_t        push_pkt
);

	localparam logic [1:0] PH_FLAGS = 2'd0;
	localparam logic [1:0] PH_X     = 2'd1;
	localparam logic [1:0] PH_Y     = 2'd2;

	localparam int SYNC_BIT  = 3;
	localparam int XSIGN_BIT = 4;
	localparam int YSIGN_BIT = 5;
	localparam int XOVF_BIT  = 6;
	localparam int YOVF_BIT  = 7;

	logic [1:0] phase_q;
	logic       skip_q;
	logic [7:0] flags_q;
	logic [7:0] xbyte_q;
	logic       accept;

	// Nine-bit sign extension of the byte, then a further 255 on overflow.
	function automatic delta_t form_delta(logic [7:0] mag, logic neg, logic ovf);
		delta_t d;
		d = neg ? {2'b11, mag} : {2'b00, mag};
		if (ovf) begin
			d = neg ? d - delta_t'(255) : d + delta_t'(255);
		end
		return d;
	endfunction

	// Only the byte that closes a packet needs room in the queue.
	assign bytes.ready = skip_q || (phase_q != PH_Y) || !queue_full;
	assign accept      = bytes.valid && bytes.ready;
	assign push        = accept && !skip_q && (phase_q == PH_Y);

	always_comb begin
		push_pkt.dx     = form_delta(xbyte_q, flags_q[XSIGN_BIT], flags_q[XOVF_BIT]);
		push_pkt.dy     = form_delta(bytes.rx_byte, flags_q[YSIGN_BIT], flags_q[YOVF_BIT]);
		push_pkt.left   = flags_q[0];
		push_pkt.right  = flags_q[1];
		push_pkt.middle = flags_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAGS;
			skip_q  <= 1'b1;
			flags_q <= '0;
			xbyte_q <= '0;
		end else if (accept) begin
			if (skip_q) begin
				skip_q <= 1'b0;
			end else begin
				unique case (phase_q)
					PH_X: begin
						xbyte_q <= bytes.rx_byte;
						phase_q <= PH_Y;
					end
					PH_Y: begin
						phase_q <= PH_FLAGS;
					end
					default: begin
						// Resynchronize: a packet starts only on a byte with the sync bit.
						if (bytes.rx_byte[SYNC_BIT]) begin
							flags_q <= bytes.rx_byte;
							phase_q <= PH_X;
						end else begin
							phase_q <= PH_FLAGS;
						end
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/pmpt_fifo.sv =====
// Short packet queue between the framing front end and the cursor back end.
// Depends on pmpt_pkg for the packet type.
module pmpt_fifo import pmpt_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pkt_t push_pkt,
	output logic full,
	input  logic pop,
	output logic rd_valid,
	output pkt_t rd_pkt
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	pkt_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_pkt   = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/pmpt_back.sv =====
// Back end: applies packet deltas to the cursor, clamps to the screen, holds the report.
// Depends on pmpt_pkg and the cursor channel interface.
module pmpt_back import pmpt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pkt_valid,
	input  pkt_t             pkt,
	output logic             pop,
	input  logic [REG_W-1:0] screen_width,
	input  logic [REG_W-1:0] screen_height,
	pmpt_cursor_if.source    report
);

	localparam int SUM_W = COORD_BITS + 2;
	localparam int LIM_W = (COORD_BITS + 1 > REG_W) ? COORD_BITS + 1 : REG_W;
	localparam logic [LIM_W-1:0] LIM_CAP = LIM_W'(1) << COORD_BITS;

	logic [COORD_BITS-1:0] pos_x_q;
	logic [COORD_BITS-1:0] pos_y_q;
	logic [2:0]            btn_q;
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] next_x;
	logic [COORD_BITS-1:0] next_y;
	delta_t                neg_dy;

	function automatic logic [COORD_BITS-1:0] clamp_axis(logic [COORD_BITS-1:0] pos,
		delta_t d, logic [REG_W-1:0] size);
		logic signed [SUM_W-1:0] v;
		logic [LIM_W-1:0]        sz;
		logic [COORD_BITS-1:0]   maxv;
		logic [COORD_BITS-1:0]   res;
		v  = $signed({2'b00, pos}) + $signed({{(SUM_W - DELTA_W){d[DELTA_W-1]}}, d});
		sz = LIM_W'(size);
		// An empty screen pins the axis at zero; an oversize one is capped to the field.
		if (sz == '0) begin
			maxv = '0;
		end else if (sz >= LIM_CAP) begin
			maxv = '1;
		end else begin
			maxv = COORD_BITS'(sz - LIM_W'(1));
		end
		if (v < 0) begin
			res = '0;
		end else if (v > $signed({2'b00, maxv})) begin
			res = maxv;
		end else begin
			res = COORD_BITS'(v);
		end
		return res;
	endfunction

	// Y grows downward on screen, so the mouse delta is subtracted.
	assign neg_dy = -pkt.dy;
	assign next_x = clamp_axis(pos_x_q, pkt.dx, screen_width);
	assign next_y = clamp_axis(pos_y_q, neg_dy, screen_height);
	assign pop    = pkt_valid && (!out_valid_q || report.ready);

	// The position registers double as the report payload: they change only on pop.
	assign report.valid         = out_valid_q;
	assign report.cursor_x      = pos_x_q;
	assign report.cursor_y      = pos_y_q;
	assign report.left_button   = btn_q[0];
	assign report.middle_button = btn_q[1];
	assign report.right_button  = btn_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			btn_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_x_q     <= next_x;
				pos_y_q     <= next_y;
				btn_q       <= {pkt.right, pkt.middle, pkt.left};
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/ps2_mouse_packet_tracker_top.sv =====
// PS/2 mouse packet tracker: top level with the screen size registers.
// Depends on pmpt_pkg, pmpt_if, pmpt_front, pmpt_fifo and pmpt_back.
//
// Usage: received mouse bytes enter on the bytes channel, one word per accepted
// handshake. The first word after reset is discarded; after that the block frames
// flags, X and Y words, starting a packet only on a flags word with bit 3 set.
// Each completed packet yields one word on the report channel: the clamped cursor
// position (zero at the top left) and the three button bits.
// Throughput is one input word per cycle while the bytes channel is not stalled.
// A report passes from the word that closes its packet through the packet queue,
// then the cursor update stage, which is also the report's output register.
// When the receiver stalls, reports wait in that register and in the queue; the
// bytes channel keeps accepting flags and X words and stalls only on a word that
// closes a packet while the queue is full. Reset clears the cursor to (0,0), the
// buttons, the framing state, and sets the screen to 1024 by 768. The user is to
// give screen size writes on the configuration port only while the block is idle;
// the block does not enforce it. They apply from the next completed packet on.
module ps2_mouse_packet_tracker_top import pmpt_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pmpt_byte_if.sink            bytes,
	pmpt_cursor_if.source        report,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	logic [REG_W-1:0] screen_width_q;
	logic [REG_W-1:0] screen_height_q;
	logic             push;
	pkt_t             push_pkt;
	logic             queue_full;
	logic             pop;
	logic             pkt_valid;
	pkt_t             pkt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RESET;
			screen_height_q <= SCREEN_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pmpt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.queue_full (queue_full),
		.push       (push),
		.push_pkt   (push_pkt)
	);

	pmpt_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.full     (queue_full),
		.pop      (pop),
		.rd_valid (pkt_valid),
		.rd_pkt   (pkt)
	);

	pmpt_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pkt_valid     (pkt_valid),
		.pkt           (pkt),
		.pop           (pop),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.report        (report)
	);

endmodule

// ===== rtl/core/pmpt_checker.sv =====
// Port-level checker for the PS/2 mouse packet tracker, bound to the top level.
// Depends on pmpt_pkg and the macros header ps2_mouse_packet_tracker_top_macros.svh.
`include "ps2_mouse_packet_tracker_top_macros.svh"

module pmpt_checker import pmpt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] cursor_x,
	input logic [COORD_BITS-1:0] cursor_y,
	input logic                  left_button,
	input logic                  middle_button,
	input logic                  right_button
);

	`PMPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "report word dropped while stalled")
	`PMPT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(cursor_x) && $stable(cursor_y) && $stable(left_button) && $stable(middle_button) && $stable(right_button), "report word changed while stalled")
	// A report with nothing queued behind it traces to the byte that closed its packet.
	`PMPT_ASSERT_SAME(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2), "report without a closing byte")
	// With the report register empty the queue cannot be full, so bytes flow.
	`PMPT_ASSERT_SAME(a_in_open, !out_valid, in_ready, "byte channel stalled with no pending report")

endmodule

bind ps2_mouse_packet_tracker_top pmpt_checker #(
	.COORD_BITS (COORD_BITS)
) u_pmpt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (bytes.valid),
	.in_ready      (bytes.ready),
	.out_valid     (report.valid),
	.out_ready     (report.ready),
	.cursor_x      (report.cursor_x),
	.cursor_y      (report.cursor_y),
	.left_button   (report.left_button),
	.middle_button (report.middle_button),
	.right_button  (report.right_button)
);

// ===== tb/pmpt_report_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the PS/2 mouse packet tracker: predicts cursor words from accepted bytes
// and screen writes, then compares them with the report channel. Uses pmpt_pkg and pmpt_if.
module pmpt_report_checker import pmpt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pmpt_byte_if                 bytes,
	pmpt_cursor_if               report,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   reports_pending
);

	// Bit positions in the flags byte.
	localparam int LEFT_POS   = 0;
	localparam int RIGHT_POS  = 1;
	localparam int MIDDLE_POS = 2;
	localparam int SYNC_POS   = 3;
	localparam int X_SIGN_POS = 4;
	localparam int Y_SIGN_POS = 5;
	localparam int X_OVF_POS  = 6;
	localparam int Y_OVF_POS  = 7;

	localparam delta_t OVF_EXTRA = 10'sd255;

	typedef enum logic [1:0] {AWAIT_FLAGS, AWAIT_X, AWAIT_Y} frame_phase_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  left;
		logic                  middle;
		logic                  right;
	} cursor_word_t;

	frame_phase_t          frame_phase;
	logic [7:0]            held_flags;
	logic [7:0]            held_x;
	logic                  drop_next;
	logic [COORD_BITS-1:0] cur_x;
	logic [COORD_BITS-1:0] cur_y;
	logic [REG_W-1:0]      screen_w;
	logic [REG_W-1:0]      screen_h;
	cursor_word_t          due_cursor_words [$];
	cursor_word_t          want;
	delta_t                dx;
	delta_t                dy;
	int                    fail_count;

	// Nine-bit two's complement value from sign and byte, pushed 255 further on overflow.
	function automatic delta_t motion_delta(input logic [7:0] mag, input logic neg,
		input logic ovf);
		delta_t d;
		d = {neg, neg, mag};
		if (ovf) begin
			d = neg ? d - OVF_EXTRA : d + OVF_EXTRA;
		end
		return d;
	endfunction

	// A zero size behaves as one; sizes past the coordinate field saturate to its range.
	function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [COORD_BITS-1:0] pos,
		input int delta, input logic [REG_W-1:0] size);
		int span;
		int moved;
		span = int'(size);
		if (span == 0) begin
			span = 1;
		end
		if (span > (1 << COORD_BITS)) begin
			span = 1 << COORD_BITS;
		end
		moved = int'(pos) + delta;
		if (moved < 0) begin
			moved = 0;
		end
		if (moved > span - 1) begin
			moved = span - 1;
		end
		return moved[COORD_BITS-1:0];
	endfunction

	task automatic compare_field(input string name, input logic [15:0] expected_value,
		input logic [15:0] actual_value);
		if (actual_value !== expected_value) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
				expected_value, actual_value);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_phase = AWAIT_FLAGS;
			held_flags = '0;
			held_x = '0;
			drop_next = 1'b1;
			cur_x = '0;
			cur_y = '0;
			screen_w = SCREEN_WIDTH_RESET;
			screen_h = SCREEN_HEIGHT_RESET;
			due_cursor_words.delete();
			fail_count = 0;
			mismatches <= 0;
			reports_pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SCREEN_WIDTH) begin
					screen_w = cfg_data;
				end else if (cfg_index == REG_SCREEN_HEIGHT) begin
					screen_h = cfg_data;
				end
			end

			if (report.valid && report.ready) begin
				if (due_cursor_words.size() == 0) begin
					fail_count++;
					$display("%0t: cursor word with none expected, %s x=%0d y=%0d",
						$time, "expected nothing, got", report.cursor_x,
						report.cursor_y);
				end else begin
					want = due_cursor_words.pop_front();
					compare_field("cursor_x", 16'(want.x), 16'(report.cursor_x));
					compare_field("cursor_y", 16'(want.y), 16'(report.cursor_y));
					compare_field("left_button", 16'(want.left),
						16'(report.left_button));
					compare_field("middle_button", 16'(want.middle),
						16'(report.middle_button));
					compare_field("right_button", 16'(want.right),
						16'(report.right_button));
				end
			end

			if (bytes.valid && bytes.ready) begin
				if (drop_next) begin
					drop_next = 1'b0;
				end else begin
					case (frame_phase)
						AWAIT_X: begin
							held_x = bytes.rx_byte;
							frame_phase = AWAIT_Y;
						end
						AWAIT_Y: begin
							dx = motion_delta(held_x, held_flags[X_SIGN_POS],
								held_flags[X_OVF_POS]);
							dy = motion_delta(bytes.rx_byte, held_flags[Y_SIGN_POS],
								held_flags[Y_OVF_POS]);
							// Screen y grows downward, so a positive mouse Y moves the cursor up.
							cur_x = clamp_coord(cur_x, int'(dx), screen_w);
							cur_y = clamp_coord(cur_y, -int'(dy), screen_h);
							want.x = cur_x;
							want.y = cur_y;
							want.left = held_flags[LEFT_POS];
							want.middle = held_flags[MIDDLE_POS];
							want.right = held_flags[RIGHT_POS];
							due_cursor_words.push_back(want);
							frame_phase = AWAIT_FLAGS;
						end
						default: begin
							if (bytes.rx_byte[SYNC_POS]) begin
								held_flags = bytes.rx_byte;
								frame_phase = AWAIT_X;
							end
						end
					endcase
				end
			end

			mismatches <= fail_count;
			reports_pending <= due_cursor_words.size();
		end
	end

endmodule

// ===== tb/tb_ps2_mouse_packet_tracker_top.sv =====
`timescale 1ns / 1ps
// Top of the PS/2 mouse packet tracker testbench: clock, reset, byte stimulus, screen writes,
// report stalls and the verdict. Depends on pmpt_pkg, pmpt_if and pmpt_report_checker.
module tb_ps2_mouse_packet_tracker_top;
	import pmpt_pkg::*;

	localparam logic [7:0] SYNC_FLAG = 8'h08;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 190;
	localparam int SETTLE_CYCLES  = 10;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum {ALWAYS_READY, RANDOM_READY, MOSTLY_STALLED, PERIODIC_READY} stall_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;
	int                   mismatches;
	int                   reports_pending;
	int                   burst_left;

	pmpt_byte_if   bytes_if ();
	pmpt_cursor_if report_if ();

	ps2_mouse_packet_tracker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes_if),
		.report    (report_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pmpt_report_checker report_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.bytes           (bytes_if),
		.report          (report_if),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.reports_pending (reports_pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// The sender works in bursts; a new burst may start after a gap, so gaps land on any
	// byte of a packet. Returns right after the edge that accepted the word.
	task automatic send_word(input logic [7:0] value);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(300, 100) :
				$urandom_range(12, 1);
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(15, 1);
			if (gap > 0) begin
				bytes_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		bytes_if.valid <= 1'b1;
		bytes_if.rx_byte <= value;
		do @(posedge clk); while (!bytes_if.ready);
	endtask

	task automatic send_packet(input logic [7:0] flags, input logic [7:0] x_byte,
		input logic [7:0] y_byte);
		send_word(flags);
		send_word(x_byte);
		send_word(y_byte);
	endtask

	// neg_pct steers the drift: low values push the cursor right and down.
	task automatic send_random_packet(input int neg_pct);
		logic [7:0] flags;
		// Layout: Y overflow, X overflow, Y sign, X sign, sync, three buttons.
		flags = {$urandom_range(99) < 25, $urandom_range(99) < 25,
			$urandom_range(99) >= neg_pct, $urandom_range(99) < neg_pct, 1'b1, 3'($urandom)};
		send_packet(flags, 8'($urandom), 8'($urandom));
	endtask

	// Let every outstanding cursor word arrive, then give the pipeline time to go quiet.
	task automatic drain_reports();
		bytes_if.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (reports_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : report_stalls
		stall_mode_t mode;
		int          mode_left;
		int          tick;
		report_if.ready <= 1'b0;
		mode = ALWAYS_READY;
		mode_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = stall_mode_t'($urandom_range(3));
				mode_left = $urandom_range(300, 40);
			end
			mode_left--;
			tick++;
			case (mode)
				ALWAYS_READY:   report_if.ready <= 1'b1;
				RANDOM_READY:   report_if.ready <= ($urandom_range(2) != 0);
				MOSTLY_STALLED: report_if.ready <= ($urandom_range(5) == 0);
				default:        report_if.ready <= ((tick % 23) >= 15);
			endcase
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (bytes_if.valid && bytes_if.ready) ||
				(report_if.valid && report_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int w;
		int h;
		int neg_pct;
		int phase_items;
		arst_n <= 1'b0;
		bytes_if.valid <= 1'b0;
		bytes_if.rx_byte <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= '0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset screen. The first word after reset is thrown away
		// even though it looks like a flags byte.
		send_word(8'h08);
		send_word(8'h00);
		send_word(8'hF7);
		send_packet(8'h08, 8'hFF, 8'h00);
		// Negative sign with a zero byte must give -256.
		send_packet(8'h19, 8'h00, 8'hFF);
		send_packet(8'h2A, 8'h01, 8'h00);
		send_packet(8'hCC, 8'hFF, 8'hFF);
		send_packet(8'hF8, 8'h00, 8'h00);
		send_packet(8'h0F, 8'h80, 8'h7F);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					w = 1;
					h = 1;
					neg_pct = 50;
				end
				1: begin
					w = 0;
					h = 0;
					neg_pct = 50;
				end
				2: begin
					w = 8192;
					h = 8192;
					neg_pct = 10;
				end
				3: begin
					w = 16383;
					h = 16383;
					neg_pct = 10;
				end
				4: begin
					w = $urandom_range(64, 1);
					h = $urandom_range(64, 1);
					neg_pct = 50;
				end
				5: begin
					w = $urandom_range(8192, 1);
					h = $urandom_range(8192, 1);
					neg_pct = 90;
				end
				6: begin
					w = 300;
					h = 200;
					neg_pct = 50;
				end
				default: begin
					w = $urandom_range(16383);
					h = $urandom_range(16383);
					neg_pct = 50;
				end
			endcase

			drain_reports();
			cfg_we <= 1'b1;
			cfg_index <= REG_SCREEN_WIDTH;
			cfg_data <= REG_W'(w);
			@(posedge clk);
			cfg_index <= REG_SCREEN_HEIGHT;
			cfg_data <= REG_W'(h);
			@(posedge clk);
			cfg_we <= 1'b0;
			@(posedge clk);

			// Mostly clean packets; the rest are stray words and cut-off packets that
			// knock the framing out of step.
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(99) < 12) begin
					if ($urandom_range(1) == 0) begin
						send_word(8'($urandom));
						phase_items += 1;
					end else begin
						send_word(8'($urandom) | SYNC_FLAG);
						send_word(8'($urandom));
						phase_items += 2;
					end
				end else begin
					send_random_packet(neg_pct);
					phase_items += 3;
				end
			end
		end

		drain_reports();
		if (mismatches == 0 && reports_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pmpt_pkg.sv
rtl/core/pmpt_if.sv
rtl/core/pmpt_front.sv
rtl/core/pmpt_fifo.sv
rtl/core/pmpt_back.sv
rtl/core/ps2_mouse_packet_tracker_top.sv
rtl/core/pmpt_checker.sv
tb/pmpt_report_checker.sv
tb/tb_ps2_mouse_packet_tracker_top.sv
